/* src/btpc_pkg.sv */
// btpc_pkg: shared types and constants for the barometric compensation block
`default_nettype none
package btpc_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MC      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MD      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd6;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] B4_BIAS   = 32'sd32768;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] P_C1      = 32'sd3038;
    localparam logic signed [31:0] P_C2      = -32'sd7375;
    localparam logic signed [31:0] P_C3      = 32'sd3791;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_X1, S_T_DEN, S_T_DIVW, S_T_FIN,
        S_P_SQ, S_P_X1, S_P_X2, S_P_B3M, S_P_B3,
        S_P_Y1, S_P_Y2, S_P_B4, S_P_B7, S_P_DIVW,
        S_P_Q, S_P_Z1, S_P_Z2, S_P_Z3, S_P_FIN,
        S_OUT
    } t_state;

    // divider request: unsigned 32/32
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;
endpackage
`default_nettype wire

/* src/btpc_mul.sv */
// btpc_mul: shared registered 32x32 multiplier, low 32 bits of the product
`default_nettype none
module btpc_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_p
);
    logic [31:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

/* src/btpc_div.sv */
// btpc_div: restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module btpc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire btpc_pkg::t_div_req i_req,
    output btpc_pkg::t_div_rsp      o_rsp
);
    logic [31:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] trial;

    always_comb begin
        trial = {r_rem, r_q[31]} - {1'b0, r_dvs};
        n_q   = {r_q[30:0], ~trial[32]};
        n_rem = trial[32] ? {r_rem[30:0], r_q[31]} : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule
`default_nettype wire

/* src/baro_temp_pressure_compensation_top.sv */
// baro_temp_pressure_compensation_top: sequenced integer compensation of raw readings
//
//  channel   dir  signals                          accept
//  s_axis    in   i_s_axis_tvalid/tready/tdata     tvalid & tready
//  m_axis    out  o_m_axis_tvalid/tready/tdata/tuser  tvalid & tready
//  cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata   i_cfg_we
//
// temperature and pressure each step through their own states; one 32-bit divider
// and one registered multiplier set the length
// one word at a time: tready is high only in idle, the result waits in
// the output register until taken
// synchronous active-low reset clears the sequencer, B5, B6, output valid and cfg registers (OSS to 3)
`default_nettype none
module baro_temp_pressure_compensation_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // op[0], raw_sample[24:1], zeros
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // value[31:0]
    output logic      [1:0]  o_m_axis_tuser,   // is_pressure[0], div_fault[1]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);
    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12;
    logic [15:0] r_mc, r_md;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0; r_ac34 <= '0; r_ac56 <= '0; r_b12 <= '0;
            r_mc <= '0; r_md <= '0; r_oss <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btpc_pkg::REG_AC1_AC2: r_ac12 <= i_cfg_wdata;
                btpc_pkg::REG_AC3_AC4: r_ac34 <= i_cfg_wdata;
                btpc_pkg::REG_AC5_AC6: r_ac56 <= i_cfg_wdata;
                btpc_pkg::REG_B1_B2:   r_b12  <= i_cfg_wdata;
                btpc_pkg::REG_MC:      r_mc   <= i_cfg_wdata[15:0];
                btpc_pkg::REG_MD:      r_md   <= i_cfg_wdata[15:0];
                btpc_pkg::REG_OSS:     r_oss  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] ac4, ac5, ac6;
    assign ac1 = 32'(signed'(r_ac12[31:16]));
    assign ac2 = 32'(signed'(r_ac12[15:0]));
    assign ac3 = 32'(signed'(r_ac34[31:16]));
    assign ac4 = {16'd0, r_ac34[15:0]};
    assign ac5 = {16'd0, r_ac56[31:16]};
    assign ac6 = {16'd0, r_ac56[15:0]};
    assign b1  = 32'(signed'(r_b12[31:16]));
    assign b2  = 32'(signed'(r_b12[15:0]));
    assign mc  = 32'(signed'(r_mc));
    assign md  = 32'(signed'(r_md));

    btpc_pkg::t_state r_st, n_st;
    logic r_pulse;  // multiplier output valid in the cycle after entering a state
    logic r_op;
    logic [23:0] r_raw;
    logic signed [31:0] r_b5, r_b6, r_t0, r_t1, r_t2, r_t3;
    logic r_neg;
    logic [31:0] r_val;
    logic r_isp, r_flt, r_ov;

    logic [31:0] mul_a, mul_b, mul_p;
    btpc_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    btpc_pkg::t_div_req div_req;
    btpc_pkg::t_div_rsp div_rsp;
    btpc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_st == btpc_pkg::S_IDLE);

    logic signed [31:0] mp;
    assign mp = signed'(mul_p);
    logic [31:0] up;
    assign up = 32'({8'd0, r_raw} >> (4'd8 - {2'd0, r_oss}));
    logic signed [31:0] t_den;
    assign t_den = r_t0 + md;
    logic signed [31:0] mc2k;
    assign mc2k = mc <<< 11;
    logic [31:0] b4w;
    assign b4w = r_t2;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            btpc_pkg::S_IDLE: if (s_acc)
                n_st = (i_s_axis_tdata[0] == btpc_pkg::OP_PRESS) ? btpc_pkg::S_P_SQ
                                                                 : btpc_pkg::S_T_X1;
            btpc_pkg::S_T_X1:  if (r_pulse) n_st = btpc_pkg::S_T_DEN;
            btpc_pkg::S_T_DEN: n_st = (t_den == 0) ? btpc_pkg::S_OUT : btpc_pkg::S_T_DIVW;
            btpc_pkg::S_T_DIVW: if (div_rsp.done) n_st = btpc_pkg::S_T_FIN;
            btpc_pkg::S_T_FIN: n_st = btpc_pkg::S_OUT;
            btpc_pkg::S_P_SQ:  if (r_pulse) n_st = btpc_pkg::S_P_X1;
            btpc_pkg::S_P_X1:  if (r_pulse) n_st = btpc_pkg::S_P_X2;
            btpc_pkg::S_P_X2:  if (r_pulse) n_st = btpc_pkg::S_P_B3M;
            btpc_pkg::S_P_B3M: if (r_pulse) n_st = btpc_pkg::S_P_B3;
            btpc_pkg::S_P_B3:  n_st = btpc_pkg::S_P_Y1;
            btpc_pkg::S_P_Y1:  if (r_pulse) n_st = btpc_pkg::S_P_Y2;
            btpc_pkg::S_P_Y2:  if (r_pulse) n_st = btpc_pkg::S_P_B4;
            btpc_pkg::S_P_B4:  if (r_pulse) n_st = btpc_pkg::S_P_B7;
            btpc_pkg::S_P_B7:  if (r_pulse)
                n_st = (r_t2 == 0) ? btpc_pkg::S_OUT : btpc_pkg::S_P_DIVW;
            btpc_pkg::S_P_DIVW: if (div_rsp.done) n_st = btpc_pkg::S_P_Q;
            btpc_pkg::S_P_Q:   n_st = btpc_pkg::S_P_Z1;
            btpc_pkg::S_P_Z1:  if (r_pulse) n_st = btpc_pkg::S_P_Z2;
            btpc_pkg::S_P_Z2:  if (r_pulse) n_st = btpc_pkg::S_P_Z3;
            btpc_pkg::S_P_Z3:  if (r_pulse) n_st = btpc_pkg::S_P_FIN;
            btpc_pkg::S_P_FIN: n_st = btpc_pkg::S_OUT;
            btpc_pkg::S_OUT:   if (!r_ov) n_st = btpc_pkg::S_IDLE;
            default: n_st = btpc_pkg::S_IDLE;
        endcase
    end

    // multiplier operands and divider requests
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (r_st)
            btpc_pkg::S_T_X1:  begin mul_a = {16'd0, r_raw[15:0]} - ac6; mul_b = ac5; end
            btpc_pkg::S_T_DEN: begin
                div_req.start    = (t_den != 0);
                div_req.dividend = mc2k[31] ? 32'(-mc2k) : mc2k;
                div_req.divisor  = t_den[31] ? 32'(-t_den) : t_den;
            end
            btpc_pkg::S_P_SQ:  begin mul_a = r_b6; mul_b = r_b6; end
            btpc_pkg::S_P_X1:  begin mul_a = b2; mul_b = r_t0; end
            btpc_pkg::S_P_X2:  begin mul_a = ac2; mul_b = r_b6; end
            btpc_pkg::S_P_B3M: begin mul_a = (ac1 <<< 2) + r_t1; mul_b = 32'd1 << r_oss; end
            btpc_pkg::S_P_Y1:  begin mul_a = ac3; mul_b = r_b6; end
            btpc_pkg::S_P_Y2:  begin mul_a = b1; mul_b = r_t0; end
            btpc_pkg::S_P_B4:  begin mul_a = ac4; mul_b = r_t1 + btpc_pkg::B4_BIAS; end
            btpc_pkg::S_P_B7:  begin
                mul_a = up - r_t3;
                mul_b = btpc_pkg::B7_SCALE >> r_oss;
                div_req.start    = r_pulse && (b4w != 0);
                div_req.dividend = mul_p[31] ? mul_p : (mul_p << 1);
                div_req.divisor  = b4w;
            end
            btpc_pkg::S_P_Z1:  begin mul_a = r_t0 >>> 8; mul_b = r_t0 >>> 8; end
            btpc_pkg::S_P_Z2:  begin mul_a = r_t1; mul_b = btpc_pkg::P_C1; end
            btpc_pkg::S_P_Z3:  begin mul_a = btpc_pkg::P_C2; mul_b = r_t0; end
            default: ;
        endcase
    end

    logic signed [31:0] b3s, b3d;
    assign b3s = mp + 32'sd2;
    assign b3d = b3s / 32'sd4;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= btpc_pkg::S_IDLE;
            r_pulse <= 1'b0;
            r_b5 <= '0;
            r_b6 <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pulse <= (n_st == r_st) && !r_pulse;
            if (o_m_axis_tvalid && i_m_axis_tready) r_ov <= 1'b0;
            if (s_acc) begin
                r_op  <= i_s_axis_tdata[0];
                r_raw <= i_s_axis_tdata[24:1];
                r_flt <= 1'b0;
                r_val <= '0;
            end
            unique case (r_st)
                btpc_pkg::S_T_X1:  if (r_pulse) r_t0 <= mp >>> 15;
                btpc_pkg::S_T_DEN: begin
                    r_neg <= mc2k[31] ^ t_den[31];
                    if (t_den == 0) begin r_flt <= 1'b1; r_ov <= 1'b1; end
                end
                btpc_pkg::S_T_DIVW: if (div_rsp.done)
                    r_b5 <= r_t0 + (r_neg ? 32'(-div_rsp.quot) : div_rsp.quot);
                btpc_pkg::S_T_FIN: begin
                    r_b6  <= r_b5 - btpc_pkg::B6_OFFSET;
                    r_val <= (r_b5 + 32'sd8) >>> 4;
                    r_ov  <= 1'b1;
                end
                btpc_pkg::S_P_SQ:  if (r_pulse) r_t0 <= mp >>> 12;
                btpc_pkg::S_P_X1:  if (r_pulse) r_t1 <= mp >>> 11;
                btpc_pkg::S_P_X2:  if (r_pulse) r_t1 <= r_t1 + (mp >>> 11);
                btpc_pkg::S_P_B3M: if (r_pulse) r_t3 <= b3d;
                btpc_pkg::S_P_Y1:  if (r_pulse) r_t1 <= mp >>> 13;
                btpc_pkg::S_P_Y2:  if (r_pulse) r_t1 <= (r_t1 + (mp >>> 16) + 32'sd2) >>> 2;
                btpc_pkg::S_P_B4:  if (r_pulse) r_t2 <= mul_p >> 15;
                btpc_pkg::S_P_B7:  if (r_pulse) begin
                    r_t1 <= mp;
                    if (r_t2 == 0) begin r_flt <= 1'b1; r_ov <= 1'b1; end
                end
                btpc_pkg::S_P_DIVW: if (div_rsp.done)
                    r_t0 <= r_t1[31] ? (div_rsp.quot << 1) : div_rsp.quot;
                btpc_pkg::S_P_Z1:  if (r_pulse) r_t1 <= mp;
                btpc_pkg::S_P_Z2:  if (r_pulse) r_t1 <= mp >>> 16;
                btpc_pkg::S_P_Z3:  if (r_pulse) r_t1 <= r_t1 + (mp >>> 16) + btpc_pkg::P_C3;
                btpc_pkg::S_P_FIN: begin
                    r_val <= r_t0 + (r_t1 >>> 4);
                    r_ov  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_val;
    assign o_m_axis_tuser  = {r_flt, r_op};

`ifndef NO_ASSERTIONS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid) else $error("ready while result pending");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata == 32'd0))
        else $error("fault with nonzero value");
    a_b6_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_st == btpc_pkg::S_T_FIN) |-> (r_b6 == r_b5 - btpc_pkg::B6_OFFSET))
        else $error("b6 out of step with b5");
`endif
endmodule
`default_nettype wire
